// ===== rtl/core/tds_pkg.sv =====
// Types, constants and saturation helpers for the tridiagonal solver core.
// Used by every module of the core and by the channel interfaces.
`default_nettype none

package tds_pkg;

    localparam int W_FIX = 48;
    localparam int W_IO  = 32;
    localparam int W_IDX = 6;

    typedef logic signed [W_FIX-1:0] t_fix;
    typedef logic        [W_FIX-1:0] t_mag;

    // Result of a shared arithmetic unit
    typedef struct packed {
        logic done;
        logic clip;
        t_fix val;
    } t_unit_res;

    // Saturated 48-bit value with its clip flag
    typedef struct packed {
        t_fix val;
        logic clip;
    } t_sat;

    // Saturated 32-bit value with its clip flag
    typedef struct packed {
        logic signed [W_IO-1:0] val;
        logic                   clip;
    } t_sat32;

    // One stored row of the forward elimination
    typedef struct packed {
        t_fix cs;
        t_fix ds;
        logic clip;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_DEN_GO,
        S_DEN_WAIT,
        S_NUM_GO,
        S_NUM_WAIT,
        S_DC_GO,
        S_DC_WAIT,
        S_DD_GO,
        S_DD_WAIT,
        S_WR,
        S_BS_INIT,
        S_BS_RD,
        S_BS_CALC,
        S_BS_WAIT,
        S_BS_OUT
    } t_state;

    function automatic t_fix sext32(input logic [W_IO-1:0] x);
        return t_fix'({{(W_FIX-W_IO){x[W_IO-1]}}, x});
    endfunction

    function automatic t_mag mag_of(input t_fix v);
        t_mag u;
        u = t_mag'(v);
        return v[W_FIX-1] ? (~u + t_mag'(1)) : u;
    endfunction

    // Apply sign to a magnitude and clip to the 48-bit range
    function automatic t_sat from_mag(input logic big, input t_mag mag, input logic neg);
        t_sat s;
        s.clip = 1'b0;
        if (neg) begin
            if (big || (mag > {1'b1, {(W_FIX-1){1'b0}}})) begin
                s.val  = t_fix'({1'b1, {(W_FIX-1){1'b0}}});
                s.clip = 1'b1;
            end else begin
                s.val = t_fix'(~mag + t_mag'(1));
            end
        end else begin
            if (big || mag[W_FIX-1]) begin
                s.val  = t_fix'({1'b0, {(W_FIX-1){1'b1}}});
                s.clip = 1'b1;
            end else begin
                s.val = t_fix'(mag);
            end
        end
        return s;
    endfunction

    // p - q saturated to 48 bits
    function automatic t_sat sub_sat48(input t_fix p, input t_fix q);
        logic [W_FIX:0] d;
        t_sat           s;
        d = {p[W_FIX-1], p} - {q[W_FIX-1], q};
        s.clip = (d[W_FIX] != d[W_FIX-1]);
        if (s.clip) begin
            s.val = d[W_FIX] ? t_fix'({1'b1, {(W_FIX-1){1'b0}}})
                             : t_fix'({1'b0, {(W_FIX-1){1'b1}}});
        end else begin
            s.val = t_fix'(d[W_FIX-1:0]);
        end
        return s;
    endfunction

    // Clip a 48-bit value to the 32-bit output range
    function automatic t_sat32 sat32(input t_fix v);
        t_sat32 s;
        s.clip = !((&v[W_FIX-1:W_IO-1]) || !(|v[W_FIX-1:W_IO-1]));
        if (s.clip) begin
            s.val = v[W_FIX-1] ? {1'b1, {(W_IO-1){1'b0}}} : {1'b0, {(W_IO-1){1'b1}}};
        end else begin
            s.val = v[W_IO-1:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tds_if.sv =====
// Channel interfaces of the tridiagonal solver core: matrix rows in, solution out.
// Depends on tds_pkg for field widths.
`default_nettype none

interface tds_row_if import tds_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic signed [W_IO-1:0] sub_diag;
    logic signed [W_IO-1:0] main_diag;
    logic signed [W_IO-1:0] super_diag;
    logic signed [W_IO-1:0] rhs;
    logic                   last_row;

    modport source (output valid, sub_diag, main_diag, super_diag, rhs, last_row,
                    input ready);
    modport sink   (input valid, sub_diag, main_diag, super_diag, rhs, last_row,
                    output ready);
endinterface

interface tds_sol_if import tds_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic signed [W_IO-1:0] solution;
    logic [W_IDX-1:0]       row_index;
    logic                   singular;
    logic                   saturated;
    logic                   last_result;

    modport source (output valid, solution, row_index, singular, saturated, last_result,
                    input ready);
    modport sink   (input valid, solution, row_index, singular, saturated, last_result,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tds_mul.sv =====
// Shared fixed-point multiplier: (x*y) >> FRAC_BITS, truncated, saturated to 48 bits.
// Four 24x24 partial products over successive cycles. Depends on tds_pkg.
`default_nettype none

module tds_mul import tds_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_start,
    input  t_fix       i_x,
    input  t_fix       i_y,
    output t_unit_res  o_res
);

    localparam int HALF = W_FIX / 2;
    localparam int W_ACC = 2 * W_FIX;

    logic             r_busy;
    logic [2:0]       r_phase;
    logic             r_done;
    t_mag             r_xm;
    t_mag             r_ym;
    logic             r_neg;
    logic [W_FIX-1:0] r_pp;
    logic [1:0]       r_pp_idx;
    logic [W_ACC-1:0] r_acc;

    logic [HALF-1:0]  w_opa;
    logic [HALF-1:0]  w_opb;
    logic [W_ACC-1:0] w_pp_sh;
    logic [W_ACC-1:0] w_t;
    t_sat             w_sat;

    // Select the halves for this phase
    always_comb begin
        unique case (r_phase[1:0])
            2'd0: begin w_opa = r_xm[HALF-1:0];     w_opb = r_ym[HALF-1:0];     end
            2'd1: begin w_opa = r_xm[W_FIX-1:HALF]; w_opb = r_ym[HALF-1:0];     end
            2'd2: begin w_opa = r_xm[HALF-1:0];     w_opb = r_ym[W_FIX-1:HALF]; end
            default: begin w_opa = r_xm[W_FIX-1:HALF]; w_opb = r_ym[W_FIX-1:HALF]; end
        endcase
    end

    // Align the previous partial product
    always_comb begin
        unique case (r_pp_idx)
            2'd0:    w_pp_sh = {{W_FIX{1'b0}}, r_pp};
            2'd3:    w_pp_sh = {r_pp, {W_FIX{1'b0}}};
            default: w_pp_sh = {{W_FIX{1'b0}}, r_pp} << HALF;
        endcase
    end

    // Drop the fraction bits and clip
    assign w_t   = r_acc >> FRAC_BITS;
    assign w_sat = from_mag(|w_t[W_ACC-1:W_FIX], w_t[W_FIX-1:0], r_neg);

    assign o_res.done = r_done;
    assign o_res.clip = w_sat.clip;
    assign o_res.val  = w_sat.val;

    // Sequence the phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 3'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 3'd0;
            end else if (r_busy) begin
                r_phase <= r_phase + 3'd1;
                if (r_phase == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Multiply one pair of halves and accumulate the previous product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xm  <= mag_of(i_x);
            r_ym  <= mag_of(i_y);
            r_neg <= i_x[W_FIX-1] ^ i_y[W_FIX-1];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_phase != 3'd4) begin
                r_pp     <= w_opa * w_opb;
                r_pp_idx <= r_phase[1:0];
            end
            if (r_phase != 3'd0) begin
                r_acc <= r_acc + w_pp_sh;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tds_div.sv =====
// Shared bit-serial divider: (n << FRAC_BITS) / d, truncated, saturated to 48 bits.
// One quotient bit per cycle, restoring form. Depends on tds_pkg.
`default_nettype none

module tds_div import tds_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_start,
    input  t_fix       i_n,
    input  t_fix       i_d,
    output t_unit_res  o_res
);

    localparam int STEPS = W_FIX + FRAC_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [CW-1:0]  r_cnt;
    logic           r_done;
    t_mag           r_n;
    t_mag           r_d;
    logic           r_neg;
    logic [W_FIX:0] r_rem;
    logic [W_FIX:0] r_q;
    logic           r_ovf;

    logic [W_FIX:0] w_trial;
    logic           w_ge;
    t_sat           w_sat;

    assign w_trial = {r_rem[W_FIX-1:0], r_n[W_FIX-1]};
    assign w_ge    = (w_trial >= {1'b0, r_d});
    assign w_sat   = from_mag(r_ovf | r_q[W_FIX], r_q[W_FIX-1:0], r_neg);

    assign o_res.done = r_done;
    assign o_res.clip = w_sat.clip;
    assign o_res.val  = w_sat.val;

    // Count the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift in one dividend bit, subtract when it fits, hold overflow sticky
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= mag_of(i_n);
            r_d   <= mag_of(i_d);
            r_neg <= i_n[W_FIX-1] ^ i_d[W_FIX-1];
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_cnt != '0) begin
            r_n   <= {r_n[W_FIX-2:0], 1'b0};
            r_rem <= w_ge ? (w_trial - {1'b0, r_d}) : w_trial;
            r_q   <= {r_q[W_FIX-1:0], w_ge};
            r_ovf <= r_ovf | r_q[W_FIX];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tridiagonal_system_solver_core.sv =====
// Top level of the tridiagonal solver (Thomas algorithm): sequencer, row store,
// shared multiplier and divider. Depends on tds_pkg, tds_if, tds_mul, tds_div.
//
//   channel  | dir | fields
//   ---------+-----+----------------------------------------------------------
//   i_row    | in  | sub_diag, main_diag, super_diag, rhs, last_row
//   o_sol    | out | solution, row_index, singular, saturated, last_result
//
// A row's time is set by two passes of the bit-serial divider; a row with a zero
// pivot skips the divider. Back substitution uses the shared multiplier and one
// row-store read port, and it waits on o_sol.ready for each unknown.
// i_row.ready is high only while idle. Reset is synchronous and needs no clearing pass.
`default_nettype none

module tridiagonal_system_solver_core import tds_pkg::*; #(
    parameter int MAX_EQUATIONS = 64,
    parameter int FRAC_BITS     = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tds_row_if.sink     i_row,
    tds_sol_if.source   o_sol
);

    localparam int AW   = (MAX_EQUATIONS > 1) ? $clog2(MAX_EQUATIONS) : 1;
    localparam int CNTW = $clog2(MAX_EQUATIONS + 1);

    t_state             r_state;
    t_state             n_state;
    logic [CNTW-1:0]    r_cnt;
    logic               r_sing;

    t_entry             r_mem [MAX_EQUATIONS];
    t_entry             r_rd;

    t_fix               r_a;
    t_fix               r_b;
    t_fix               r_c;
    t_fix               r_r;
    logic               r_last;
    t_fix               r_den;
    t_fix               r_num;
    t_fix               r_cs;
    t_fix               r_ds;
    logic               r_clip;
    logic [AW-1:0]      r_k;
    logic               r_first;
    t_fix               r_xnext;
    logic signed [W_IO-1:0] r_sol;
    logic               r_sat;

    logic               w_accept;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic               w_mul_start;
    t_fix               w_mul_x;
    t_fix               w_mul_y;
    logic               w_div_start;
    t_fix               w_div_n;
    t_unit_res          w_mul;
    t_unit_res          w_div;
    t_sat               w_den_sat;
    t_sat               w_num_sat;
    t_sat               w_bs_sat;
    t_fix               w_x;
    logic               w_x_clip;
    t_sat32             w_s32;
    logic               w_out_xfer;
    logic               w_room;

    tds_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_x     (w_mul_x),
        .i_y     (w_mul_y),
        .o_res   (w_mul)
    );

    tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (w_div_n),
        .i_d     (r_den),
        .o_res   (w_div)
    );

    assign w_accept   = i_row.valid && i_row.ready;
    assign w_out_xfer = o_sol.valid && o_sol.ready;
    assign w_room     = (r_cnt < CNTW'(MAX_EQUATIONS));

    // Saturating subtracts after each product
    assign w_den_sat = sub_sat48(r_b, w_mul.val);
    assign w_num_sat = sub_sat48(r_r, w_mul.val);
    assign w_bs_sat  = sub_sat48(r_rd.ds, w_mul.val);
    assign w_x       = r_first ? r_rd.ds : w_bs_sat.val;
    assign w_x_clip  = r_first ? 1'b0 : (w_mul.clip | w_bs_sat.clip);
    assign w_s32     = sat32(w_x);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_state = S_RD;
                    end else if (i_row.last_row) begin
                        n_state = S_BS_INIT;
                    end
                end
            end
            S_RD:       n_state = S_DEN_GO;
            S_DEN_GO:   n_state = S_DEN_WAIT;
            S_DEN_WAIT: if (w_mul.done) n_state = S_NUM_GO;
            S_NUM_GO:   n_state = S_NUM_WAIT;
            S_NUM_WAIT: begin
                if (w_mul.done) begin
                    n_state = (r_den == '0) ? S_WR : S_DC_GO;
                end
            end
            S_DC_GO:    n_state = S_DC_WAIT;
            S_DC_WAIT:  if (w_div.done) n_state = S_DD_GO;
            S_DD_GO:    n_state = S_DD_WAIT;
            S_DD_WAIT:  if (w_div.done) n_state = S_WR;
            S_WR:       n_state = r_last ? S_BS_INIT : S_IDLE;
            S_BS_INIT:  n_state = S_BS_RD;
            S_BS_RD:    n_state = S_BS_CALC;
            S_BS_CALC:  n_state = r_first ? S_BS_OUT : S_BS_WAIT;
            S_BS_WAIT:  if (w_mul.done) n_state = S_BS_OUT;
            S_BS_OUT: begin
                if (w_out_xfer) begin
                    n_state = (r_k == '0) ? S_IDLE : S_BS_RD;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        i_row.ready = 1'b0;
        o_sol.valid = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_k;
        w_mul_start = 1'b0;
        w_mul_x     = r_a;
        w_mul_y     = (r_cnt == '0) ? t_fix'(0) : r_rd.cs;
        w_div_start = 1'b0;
        w_div_n     = r_c;
        unique case (r_state)
            S_IDLE: i_row.ready = 1'b1;
            S_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = AW'(r_cnt - CNTW'(1));
            end
            S_DEN_GO: w_mul_start = 1'b1;
            S_NUM_GO: begin
                w_mul_start = 1'b1;
                w_mul_y     = (r_cnt == '0) ? t_fix'(0) : r_rd.ds;
            end
            S_DC_GO: w_div_start = 1'b1;
            S_DD_GO: begin
                w_div_start = 1'b1;
                w_div_n     = r_num;
            end
            S_BS_RD: w_rd_en = 1'b1;
            S_BS_CALC: begin
                w_mul_start = !r_first;
                w_mul_x     = r_rd.cs;
                w_mul_y     = r_xnext;
            end
            S_BS_OUT: o_sol.valid = 1'b1;
            default: ;
        endcase
    end

    assign o_sol.solution    = r_sol;
    assign o_sol.row_index   = W_IDX'(r_k);
    assign o_sol.singular    = r_sing;
    assign o_sol.saturated   = r_sat;
    assign o_sol.last_result = (r_k == '0);

    // Control state: sequencer, row count, sticky zero-pivot flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sing  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WR) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
            if (r_state == S_NUM_WAIT && w_mul.done && r_den == '0) begin
                r_sing <= 1'b1;
            end
            if (r_state == S_BS_OUT && w_out_xfer && r_k == '0) begin
                r_cnt  <= '0;
                r_sing <= 1'b0;
            end
        end
    end

    // Row store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_mem[AW'(r_cnt)] <= '{cs: r_cs, ds: r_ds, clip: r_clip};
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_a    <= (r_cnt == '0) ? t_fix'(0) : sext32(i_row.sub_diag);
                    r_b    <= sext32(i_row.main_diag);
                    r_c    <= i_row.last_row ? t_fix'(0) : sext32(i_row.super_diag);
                    r_r    <= sext32(i_row.rhs);
                    r_last <= i_row.last_row;
                    r_clip <= 1'b0;
                end
            end
            S_DEN_WAIT: begin
                if (w_mul.done) begin
                    r_den  <= w_den_sat.val;
                    r_clip <= r_clip | w_mul.clip | w_den_sat.clip;
                end
            end
            S_NUM_WAIT: begin
                if (w_mul.done) begin
                    r_num  <= w_num_sat.val;
                    r_clip <= r_clip | w_mul.clip | w_num_sat.clip;
                    r_cs   <= '0;
                    r_ds   <= '0;
                end
            end
            S_DC_WAIT: begin
                if (w_div.done) begin
                    r_cs   <= w_div.val;
                    r_clip <= r_clip | w_div.clip;
                end
            end
            S_DD_WAIT: begin
                if (w_div.done) begin
                    r_ds   <= w_div.val;
                    r_clip <= r_clip | w_div.clip;
                end
            end
            S_BS_INIT: begin
                r_k     <= AW'(r_cnt - CNTW'(1));
                r_first <= 1'b1;
            end
            S_BS_CALC: begin
                if (r_first) begin
                    r_xnext <= w_x;
                    r_sol   <= w_s32.val;
                    r_sat   <= r_rd.clip | w_s32.clip;
                end
            end
            S_BS_WAIT: begin
                if (w_mul.done) begin
                    r_xnext <= w_x;
                    r_sol   <= w_s32.val;
                    r_sat   <= r_rd.clip | w_x_clip | w_s32.clip;
                end
            end
            S_BS_OUT: begin
                if (w_out_xfer && r_k != '0) begin
                    r_k     <= r_k - AW'(1);
                    r_first <= 1'b0;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
